// ===== sv/imhtq_pkg.sv =====
package imhtq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_W         = 6;
    localparam int KEY_W        = 32;
    localparam int ID_SPACE     = 64;
    localparam int OP_W         = 2;
    localparam int ST_W         = 3;
    localparam int CNT_OUT_W    = 7;
    localparam int SLOT_W       = ID_W + KEY_W;
    localparam int CMD_W        = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [ST_W-1:0] ST_DUP    = 3'd4;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_NONE      = 4'd0;
    localparam t_cmd CMD_LOAD      = 4'd1;
    localparam t_cmd CMD_CHECK     = 4'd2;
    localparam t_cmd CMD_TAKE_LAST = 4'd3;
    localparam t_cmd CMD_RISE_READ = 4'd4;
    localparam t_cmd CMD_RISE_MOVE = 4'd5;
    localparam t_cmd CMD_PUT       = 4'd6;
    localparam t_cmd CMD_SINK_READ = 4'd7;
    localparam t_cmd CMD_SINK_MOVE = 4'd8;
    localparam t_cmd CMD_EMIT      = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [ID_W-1:0]  entry_id;
        logic [KEY_W-1:0] expiry_key;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [ID_W-1:0]      removed_id;
        logic [KEY_W-1:0]     removed_key;
        logic                 front_valid;
        logic [ID_W-1:0]      front_id;
        logic [KEY_W-1:0]     front_key;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            check_ok;
        logic            count_one;
        logic            key_lt_old;
        logic            pos_zero;
        logic            parent_le;
        logic            sink_leaf;
        logic            sink_stop;
        logic            out_busy;
    } t_dp_status;

endpackage

// ===== sv/imhtq_ram.sv =====
module imhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/imhtq_ctrl.sv =====
module imhtq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  imhtq_pkg::t_dp_status i_status,
    output imhtq_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_LAST     = 4'd2;
    localparam logic [3:0] S_OLD      = 4'd3;
    localparam logic [3:0] S_RISE_CHK = 4'd4;
    localparam logic [3:0] S_RISE_CMP = 4'd5;
    localparam logic [3:0] S_SINK_CHK = 4'd6;
    localparam logic [3:0] S_SINK_CMP = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = imhtq_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = imhtq_pkg::CMD_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd = imhtq_pkg::CMD_CHECK;
                priority if (!i_status.check_ok) begin
                    n_state = S_DONE;
                end else if (i_status.op == imhtq_pkg::OP_INSERT) begin
                    n_state = S_RISE_CHK;
                end else if (i_status.op == imhtq_pkg::OP_REMOVE) begin
                    n_state = i_status.count_one ? S_DONE : S_LAST;
                end else if (i_status.op == imhtq_pkg::OP_CHANGE) begin
                    n_state = S_OLD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST: begin
                o_cmd   = imhtq_pkg::CMD_TAKE_LAST;
                n_state = S_SINK_CHK;
            end
            S_OLD: begin
                n_state = i_status.key_lt_old ? S_RISE_CHK : S_SINK_CHK;
            end
            S_RISE_CHK: begin
                if (i_status.pos_zero) begin
                    o_cmd   = imhtq_pkg::CMD_PUT;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imhtq_pkg::CMD_RISE_READ;
                    n_state = S_RISE_CMP;
                end
            end
            S_RISE_CMP: begin
                if (i_status.parent_le) begin
                    o_cmd   = imhtq_pkg::CMD_PUT;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imhtq_pkg::CMD_RISE_MOVE;
                    n_state = S_RISE_CHK;
                end
            end
            S_SINK_CHK: begin
                if (i_status.sink_leaf) begin
                    o_cmd   = imhtq_pkg::CMD_PUT;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imhtq_pkg::CMD_SINK_READ;
                    n_state = S_SINK_CMP;
                end
            end
            S_SINK_CMP: begin
                if (i_status.sink_stop) begin
                    o_cmd   = imhtq_pkg::CMD_PUT;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = imhtq_pkg::CMD_SINK_MOVE;
                    n_state = S_SINK_CHK;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd   = imhtq_pkg::CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== sv/imhtq_dpath.sv =====
module imhtq_dpath #(
    parameter int CAPACITY = imhtq_pkg::CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imhtq_pkg::t_cmd       i_cmd,
    output imhtq_pkg::t_dp_status o_status,
    input  imhtq_pkg::t_in_word   i_in_word,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output imhtq_pkg::t_out_word  o_out_word
);

    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = PW + 2;
    localparam int IDS = imhtq_pkg::ID_SPACE;

    logic [imhtq_pkg::OP_W-1:0]  r_op;
    logic [imhtq_pkg::ID_W-1:0]  r_id;
    logic [imhtq_pkg::KEY_W-1:0] r_key;
    imhtq_pkg::t_slot            r_mov;
    imhtq_pkg::t_slot            r_front;
    imhtq_pkg::t_slot            r_rem;
    logic [PW-1:0]               r_pos;
    logic [CW-1:0]               r_count;
    logic [IDS-1:0]              r_present;
    logic [imhtq_pkg::ST_W-1:0]  r_status;
    logic                        r_out_valid;
    imhtq_pkg::t_out_word        r_out_word;

    logic [imhtq_pkg::SLOT_W-1:0] heap_a_raw;
    logic [imhtq_pkg::SLOT_W-1:0] heap_b_raw;
    imhtq_pkg::t_slot             heap_a;
    imhtq_pkg::t_slot             heap_b;
    logic [PW-1:0]                pm_rdata;

    logic                         heap_we;
    logic [PW-1:0]                heap_waddr;
    imhtq_pkg::t_slot             heap_wdata;
    logic [PW-1:0]                heap_raddr;

    logic [XW-1:0]                count_ext;
    logic [XW-1:0]                c_idx;
    logic [XW-1:0]                r_idx;
    logic [PW-1:0]                up_pos;
    logic [PW-1:0]                last_pos;
    logic                         right_sel;
    imhtq_pkg::t_slot             child;
    logic [PW-1:0]                child_pos;
    logic                         present_id;
    logic [imhtq_pkg::ST_W-1:0]   chk_status;
    logic                         chk_ok;
    imhtq_pkg::t_out_word         out_next;

    assign heap_a = imhtq_pkg::t_slot'(heap_a_raw);
    assign heap_b = imhtq_pkg::t_slot'(heap_b_raw);

    // two copies of the heap give two read ports for the children
    imhtq_ram #(.WIDTH(imhtq_pkg::SLOT_W), .DEPTH(CAPACITY)) u_heap_a (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_a_raw)
    );

    imhtq_ram #(.WIDTH(imhtq_pkg::SLOT_W), .DEPTH(CAPACITY)) u_heap_b (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (r_idx[PW-1:0]),
        .o_rdata (heap_b_raw)
    );

    imhtq_ram #(.WIDTH(PW), .DEPTH(IDS)) u_posmap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_wdata.id),
        .i_wdata (heap_waddr),
        .i_raddr (i_in_word.entry_id),
        .o_rdata (pm_rdata)
    );

    assign count_ext  = XW'(r_count);
    assign c_idx      = XW'({r_pos, 1'b1});
    assign r_idx      = c_idx + XW'(1);
    assign up_pos     = (r_pos - PW'(1)) >> 1;
    assign last_pos   = PW'(r_count - CW'(1));
    assign right_sel  = (r_idx < count_ext) && (heap_b.key <= heap_a.key);
    assign child      = right_sel ? heap_b : heap_a;
    assign child_pos  = right_sel ? r_idx[PW-1:0] : c_idx[PW-1:0];
    assign present_id = r_present[r_id];

    always_comb begin
        unique case (r_op)
            imhtq_pkg::OP_INSERT: begin
                priority if (present_id) begin
                    chk_status = imhtq_pkg::ST_DUP;
                end else if (r_count >= CW'(CAPACITY)) begin
                    chk_status = imhtq_pkg::ST_FULL;
                end else begin
                    chk_status = imhtq_pkg::ST_OK;
                end
            end
            imhtq_pkg::OP_REMOVE: begin
                chk_status = (r_count == '0) ? imhtq_pkg::ST_EMPTY : imhtq_pkg::ST_OK;
            end
            imhtq_pkg::OP_CHANGE: begin
                chk_status = (!present_id || (CW'(pm_rdata) >= r_count)) ?
                             imhtq_pkg::ST_ABSENT : imhtq_pkg::ST_OK;
            end
            default: begin
                chk_status = imhtq_pkg::ST_OK;
            end
        endcase
    end

    assign chk_ok = (chk_status == imhtq_pkg::ST_OK);

    always_comb begin
        heap_we    = 1'b0;
        heap_waddr = r_pos;
        heap_wdata = r_mov;
        heap_raddr = c_idx[PW-1:0];
        unique case (i_cmd)
            imhtq_pkg::CMD_CHECK: begin
                heap_raddr = (r_op == imhtq_pkg::OP_REMOVE) ? last_pos : pm_rdata;
            end
            imhtq_pkg::CMD_RISE_READ: begin
                heap_raddr = up_pos;
            end
            imhtq_pkg::CMD_RISE_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = heap_a;
            end
            imhtq_pkg::CMD_SINK_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = child;
            end
            imhtq_pkg::CMD_PUT: begin
                heap_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_next.status      = r_status;
        out_next.removed_id  = r_rem.id;
        out_next.removed_key = r_rem.key;
        out_next.front_valid = (r_count != '0);
        out_next.front_id    = (r_count != '0) ? r_front.id : '0;
        out_next.front_key   = (r_count != '0) ? r_front.key : '0;
        out_next.entry_count = imhtq_pkg::CNT_OUT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd == imhtq_pkg::CMD_EMIT) || (r_out_valid && i_out_stall);
            unique case (i_cmd)
                imhtq_pkg::CMD_CHECK: begin
                    if (chk_ok && r_op == imhtq_pkg::OP_INSERT) begin
                        r_count         <= r_count + CW'(1);
                        r_present[r_id] <= 1'b1;
                    end else if (chk_ok && r_op == imhtq_pkg::OP_REMOVE) begin
                        r_count               <= r_count - CW'(1);
                        r_present[r_front.id] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            imhtq_pkg::CMD_LOAD: begin
                r_op  <= i_in_word.operation;
                r_id  <= i_in_word.entry_id;
                r_key <= i_in_word.expiry_key;
                r_rem <= '0;
            end
            imhtq_pkg::CMD_CHECK: begin
                r_status <= chk_status;
                r_mov    <= '{id: r_id, key: r_key};
                if (chk_ok && r_op == imhtq_pkg::OP_INSERT) begin
                    r_pos <= PW'(r_count);
                end else if (chk_ok && r_op == imhtq_pkg::OP_REMOVE) begin
                    r_rem <= r_front;
                    r_pos <= '0;
                end else if (chk_ok && r_op == imhtq_pkg::OP_CHANGE) begin
                    r_pos <= pm_rdata;
                end
            end
            imhtq_pkg::CMD_TAKE_LAST: begin
                r_mov <= heap_a;
            end
            imhtq_pkg::CMD_RISE_MOVE: begin
                r_pos <= up_pos;
            end
            imhtq_pkg::CMD_SINK_MOVE: begin
                r_pos <= child_pos;
            end
            imhtq_pkg::CMD_EMIT: begin
                r_out_word <= out_next;
            end
            default: begin
            end
        endcase
        // shadow copy of the root slot
        if (heap_we && heap_waddr == '0) begin
            r_front <= heap_wdata;
        end
    end

    assign o_status.op         = r_op;
    assign o_status.check_ok   = chk_ok;
    assign o_status.count_one  = (r_count == CW'(1));
    assign o_status.key_lt_old = (r_mov.key < heap_a.key);
    assign o_status.pos_zero   = (r_pos == '0);
    assign o_status.parent_le  = (heap_a.key <= r_mov.key);
    assign o_status.sink_leaf  = (c_idx >= count_ext);
    assign o_status.sink_stop  = (r_mov.key <= child.key);
    assign o_status.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/indexed_min_heap_timer_queue_top.sv =====
// Indexed min-heap timer queue.
// Input channel: i_in_valid / o_in_stall carry one operation word (insert,
// remove minimum, change key). One operation is worked on at a time; o_in_stall
// is high from the cycle after acceptance until the result is handed to the
// output register.
// Output channel: o_out_valid / i_out_stall carry one result word per operation
// with status, removed entry, new front entry and entry count.
// Errors, the unused code and removing the only entry go from the check
// straight to the result, with no sift of the heap.
// A new word is accepted in the cycle after the result is loaded. Each heap
// level costs one registered read of the heap memory and then a compare and
// write; that sift loop sets how long an operation takes.
// Reset empties the queue at once (presence bits and count clear); the heap and
// position memories need no clearing pass.
// When the receiver stalls, the result holds in the output register; the next
// operation can still be accepted and runs, but its result waits until the
// output register is free.
module indexed_min_heap_timer_queue_top #(
    parameter int CAPACITY = imhtq_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  imhtq_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imhtq_pkg::t_out_word o_out_word
);

    imhtq_pkg::t_cmd       cmd;
    imhtq_pkg::t_dp_status dp_status;

    imhtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    imhtq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sv/imhtq_checker.sv =====
module imhtq_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_stall,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input imhtq_pkg::t_out_word i_out_word
);

    // held word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("output word changed while stalled");

    // one operation in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken again right after acceptance");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_word.front_valid |->
            i_out_word.front_id == '0 && i_out_word.front_key == '0 &&
            i_out_word.entry_count == '0)
        else $error("empty queue reports a front entry");

    a_err_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.status != imhtq_pkg::ST_OK |->
            i_out_word.removed_id == '0 && i_out_word.removed_key == '0)
        else $error("failed operation reports a removed entry");

endmodule

bind indexed_min_heap_timer_queue_top imhtq_checker u_imhtq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);

// ===== verif/timer_heap_checker.sv =====
`timescale 1ns / 100ps
module timer_heap_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  imhtq_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  imhtq_pkg::t_out_word i_out_word,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    import imhtq_pkg::*;

    localparam int unsigned SLOTS = CAPACITY_DEF;

    logic [ID_W-1:0]  heap_id  [SLOTS];
    logic [KEY_W-1:0] heap_key [SLOTS];
    logic [ID_W-1:0]  slot_of  [ID_SPACE];
    logic [ID_SPACE-1:0] held;
    int unsigned held_n;

    t_out_word results_due[$];
    int fails;
    int checked;
    int due_n;

    assign o_fail_count = fails;
    assign o_pending    = due_n;
    assign o_checked    = checked;

    function automatic void place(int unsigned p, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        heap_id[p]  = id;
        heap_key[p] = key;
        slot_of[id] = ID_W'(p);
    endfunction

    function automatic void sift_up(int unsigned p, logic [ID_W-1:0] id,
                                    logic [KEY_W-1:0] key);
        int unsigned parent;
        while (p > 0) begin
            parent = (p - 1) >> 1;
            if (heap_key[parent] <= key) break;
            place(p, heap_id[parent], heap_key[parent]);
            p = parent;
        end
        place(p, id, key);
    endfunction

    function automatic void sift_down(int unsigned p, logic [ID_W-1:0] id,
                                      logic [KEY_W-1:0] key);
        int unsigned c;
        forever begin
            c = 2 * p + 1;
            if (c >= held_n) break;
            if (c + 1 < held_n && heap_key[c+1] <= heap_key[c]) c = c + 1;
            if (key <= heap_key[c]) break;
            place(p, heap_id[c], heap_key[c]);
            p = c;
        end
        place(p, id, key);
    endfunction

    function automatic t_out_word apply_heap_op(t_in_word w);
        t_out_word r;
        int unsigned p;
        r        = '0;
        r.status = ST_OK;
        case (w.operation)
            OP_INSERT: begin
                if (held[w.entry_id]) begin
                    r.status = ST_DUP;
                end else if (held_n >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    p = held_n;
                    held_n++;
                    held[w.entry_id] = 1'b1;
                    sift_up(p, w.entry_id, w.expiry_key);
                end
            end
            OP_REMOVE: begin
                if (held_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed_id  = heap_id[0];
                    r.removed_key = heap_key[0];
                    held[heap_id[0]] = 1'b0;
                    held_n--;
                    if (held_n > 0) sift_down(0, heap_id[held_n], heap_key[held_n]);
                end
            end
            OP_CHANGE: begin
                if (!held[w.entry_id]) begin
                    r.status = ST_ABSENT;
                end else begin
                    p = slot_of[w.entry_id];
                    if (p >= held_n) r.status = ST_ABSENT;
                    else if (w.expiry_key < heap_key[p]) sift_up(p, w.entry_id, w.expiry_key);
                    else sift_down(p, w.entry_id, w.expiry_key);
                end
            end
            default: ;
        endcase
        if (held_n > 0) begin
            r.front_valid = 1'b1;
            r.front_id    = heap_id[0];
            r.front_key   = heap_key[0];
        end
        r.entry_count = CNT_OUT_W'(held_n);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    initial begin
        fails   = 0;
        checked = 0;
        due_n   = 0;
        held    = '0;
        held_n  = 0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held   = '0;
            held_n = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result word with no operation outstanding: %0h", i_out_word);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("status", want.status, i_out_word.status);
                    compare_field("removed_id", want.removed_id, i_out_word.removed_id);
                    compare_field("removed_key", want.removed_key, i_out_word.removed_key);
                    compare_field("front_valid", want.front_valid, i_out_word.front_valid);
                    compare_field("front_id", want.front_id, i_out_word.front_id);
                    compare_field("front_key", want.front_key, i_out_word.front_key);
                    compare_field("entry_count", want.entry_count, i_out_word.entry_count);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) results_due.push_back(apply_heap_op(i_in_word));
        end
        due_n = results_due.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import imhtq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int fail_count;
    int pending;
    int checked;
    int sent        = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;
    int sender_pcts [4] = '{0, 70, 0, 20};
    int stall_pcts  [4] = '{0, 0, 70, 20};

    indexed_min_heap_timer_queue_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    timer_heap_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] key);
        t_in_word w;
        w.operation  = op;
        w.entry_id   = id;
        w.expiry_key = key;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    initial begin
        logic [ID_W-1:0] order [ID_SPACE];
        logic [ID_W-1:0] tmp;
        int j;
        int r;
        int drain_len;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty queue errors, extremes, ties, equal keys, id reuse
        send_op(OP_REMOVE, 6'd0, '0);
        send_op(OP_CHANGE, 6'd0, 32'd5);
        send_op(OP_UNUSED, 6'h3f, '1);
        send_op(OP_INSERT, 6'h3f, '1);
        send_op(OP_INSERT, 6'd0, '0);
        send_op(OP_INSERT, 6'd0, 32'd7);
        send_op(OP_INSERT, 6'd5, '0);
        send_op(OP_INSERT, 6'd42, 32'h8000_0000);
        send_op(OP_INSERT, 6'd21, 32'h7fff_ffff);
        send_op(OP_CHANGE, 6'h3f, '1);
        send_op(OP_CHANGE, 6'h3f, '0);
        send_op(OP_CHANGE, 6'd0, '1);
        send_op(OP_CHANGE, 6'd21, 32'h7fff_ffff);
        send_op(OP_UNUSED, 6'd0, '0);
        send_op(OP_CHANGE, 6'd9, 32'd1);
        repeat (6) send_op(OP_REMOVE, 6'd0, '0);
        send_op(OP_INSERT, 6'h3f, 32'd1);
        send_op(OP_CHANGE, 6'd42, 32'd3);
        send_op(OP_REMOVE, 6'd0, '0);

        for (int round = 0; round < 4; round++) begin
            idle_pct  = sender_pcts[round];
            stall_pct = stall_pcts[round];

            // fill with every id in shuffled order
            for (int i = 0; i < ID_SPACE; i++) order[i] = ID_W'(i);
            for (int i = ID_SPACE - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < ID_SPACE; i++) send_op(OP_INSERT, order[i], pick_key());

            // churn on a mostly full heap
            for (int i = 0; i < 80; i++) begin
                r = $urandom_range(0, 99);
                if (r < 50) send_op(OP_CHANGE, ID_W'($urandom_range(0, 63)), pick_key());
                else if (r < 70) send_op(OP_REMOVE, ID_W'($urandom), $urandom);
                else if (r < 90) send_op(OP_INSERT, ID_W'($urandom_range(0, 63)), pick_key());
                else send_op(OP_UNUSED, ID_W'($urandom), $urandom);
            end

            drain_len = (round == 3) ? 66 : $urandom_range(30, 66);
            repeat (drain_len) send_op(OP_REMOVE, ID_W'($urandom), $urandom);
        end

        idle_pct = 0;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);

        $display("%0d operation words sent: directed cases, then fill, churn and drain rounds",
                 sent);
        $display("%0d result words compared under no idling, sender gaps, stalls and both",
                 checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
